>>> rtl/core/rrht_pkg.sv
`timescale 1ns / 1ps

package rrht_pkg;

  localparam int DEF_MAX_REGIONS = 16;
  localparam int DEF_COORD_BITS  = 16;

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;
  localparam int SIDE_W  = 3;

  localparam logic [KIND_W-1:0] CMD_WRITE    = 2'd0;
  localparam logic [KIND_W-1:0] CMD_FIND     = 2'd1;
  localparam logic [KIND_W-1:0] CMD_CLASSIFY = 2'd2;
  localparam logic [KIND_W-1:0] CMD_READ     = 2'd3;

  localparam logic [SIDE_W-1:0] SIDE_ALL    = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd4;
  localparam logic [SIDE_W-1:0] SIDE_NONE   = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] cmd;
    logic              idx_ok;
    logic              scan_none;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

endpackage

>>> rtl/core/rrht_front.sv
`timescale 1ns / 1ps

module rrht_front import rrht_pkg::*; #(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                cfg_valid,
  output logic                                                cfg_ready,
  input  logic [COUNT_W-1:0]                                  cfg_data,
  input  logic                                                s_tvalid,
  output logic                                                s_tready,
  input  logic [((INDEX_W + 6*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic [KIND_W-1:0]                                   s_tuser,
  output logic                                                f_valid,
  input  logic                                                f_ready,
  output ctl_t                                                f_ctl,
  output logic [((MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1) - 1:0] f_addr,
  output logic [((MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1) - 1:0] f_last,
  output logic [6*COORD_BITS-1:0]                             f_coords
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  logic [COUNT_W-1:0] region_count;
  logic [INDEX_W-1:0] idx;
  logic               idx_ok;
  logic [31:0]        n_eff;

  assign cfg_ready = 1'b1;
  assign s_tready  = !f_valid || f_ready;

  assign idx    = s_tdata[INDEX_W-1:0];
  assign idx_ok = 32'(idx) < 32'(MAX_REGIONS);
  assign n_eff  = (32'(region_count) > 32'(MAX_REGIONS)) ? 32'(MAX_REGIONS)
                                                         : 32'(region_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
      f_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        region_count <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        f_valid         <= 1'b1;
        f_ctl.cmd       <= s_tuser;
        f_ctl.idx_ok    <= idx_ok;
        f_ctl.scan_none <= (region_count == '0);
        f_addr          <= (s_tuser == CMD_FIND) ? '0 : AW'(idx);
        f_last          <= AW'(n_eff - 32'd1);
        f_coords        <= s_tdata[INDEX_W +: 6*COORD_BITS];
      end else if (f_valid && f_ready) begin
        f_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/rrht_queue.sv
`timescale 1ns / 1ps

module rrht_queue import rrht_pkg::*; #(
  parameter int W = CTL_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/rrht_back.sv
`timescale 1ns / 1ps

module rrht_back import rrht_pkg::*; #(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                q_valid,
  output logic                                                q_ready,
  input  ctl_t                                                q_ctl,
  input  logic [((MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1) - 1:0] q_addr,
  input  logic [((MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1) - 1:0] q_last,
  input  logic [6*COORD_BITS-1:0]                             q_coords,
  output logic                                                m_tvalid,
  input  logic                                                m_tready,
  output logic [((8 + 4*COORD_BITS + 7) / 8) * 8 - 1:0]       m_tdata,
  output logic [KIND_W-1:0]                                   m_tuser
);

  localparam int AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CB    = COORD_BITS;
  localparam int OUT_W = ((8 + 4*COORD_BITS + 7) / 8) * 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state;
  logic [4*CB-1:0]      mem [MAX_REGIONS];
  logic [4*CB-1:0]      rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;

  logic [KIND_W-1:0]    cur_cmd;
  logic signed [CB-1:0] cand_l, cand_t, cand_r, cand_b, pt_x, pt_y;
  logic [AW-1:0]        scan_idx;
  logic [AW-1:0]        scan_last;

  logic                 res_found;
  logic [INDEX_W-1:0]   res_hit;
  logic [SIDE_W-1:0]    res_side;
  logic [CB-1:0]        res_l, res_t, res_r, res_b;

  logic                 o_valid;
  logic                 o_load;
  logic [KIND_W-1:0]    o_kind;
  logic                 o_found;
  logic [INDEX_W-1:0]   o_hit;
  logic [SIDE_W-1:0]    o_side;
  logic [CB-1:0]        o_l, o_t, o_r, o_b;

  logic signed [CB-1:0] g_l, g_t, g_r, g_b;
  logic                 xl_in, xr_in, yt_in, yb_in;
  logic                 tl, tr, bl, br;
  logic                 pt_in;
  logic [SIDE_W-1:0]    side_calc;

  assign q_ready  = state == ST_IDLE;
  assign wr_en    = q_valid && q_ready && q_ctl.cmd == CMD_WRITE && q_ctl.idx_ok;
  assign rd_addr  = (state == ST_SCAN) ? AW'(scan_idx + 1'b1) : q_addr;
  assign o_load   = state == ST_DONE && (!o_valid || m_tready);

  assign m_tvalid = o_valid;
  assign m_tuser  = o_kind;
  assign m_tdata  = OUT_W'({o_b, o_r, o_t, o_l, o_side, o_hit, o_found});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_addr] <= q_coords[4*CB-1:0];
    end
    rd_data <= mem[rd_addr];
  end

  assign g_l = $signed(rd_data[0*CB +: CB]);
  assign g_t = $signed(rd_data[1*CB +: CB]);
  assign g_r = $signed(rd_data[2*CB +: CB]);
  assign g_b = $signed(rd_data[3*CB +: CB]);

  assign xl_in = cand_l >= g_l && cand_l < g_r;
  assign xr_in = cand_r >= g_l && cand_r < g_r;
  assign yt_in = cand_t >= g_t && cand_t < g_b;
  assign yb_in = cand_b >= g_t && cand_b < g_b;
  assign tl    = xl_in && yt_in;
  assign tr    = xr_in && yt_in;
  assign bl    = xl_in && yb_in;
  assign br    = xr_in && yb_in;
  assign pt_in = pt_x >= g_l && pt_x < g_r && pt_y >= g_t && pt_y < g_b;

  always_comb begin
    if (tl && tr && bl && br) begin
      side_calc = SIDE_ALL;
    end else if (!(tl && bl) && tr && br) begin
      side_calc = SIDE_RIGHT;
    end else if (tl && bl && !(tr && br)) begin
      side_calc = SIDE_LEFT;
    end else if (!(tl && tr) && bl && br) begin
      side_calc = SIDE_BOTTOM;
    end else if (tl && tr && !(bl && br)) begin
      side_calc = SIDE_TOP;
    end else begin
      side_calc = SIDE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur_cmd   <= q_ctl.cmd;
            cand_l    <= $signed(q_coords[0*CB +: CB]);
            cand_t    <= $signed(q_coords[1*CB +: CB]);
            cand_r    <= $signed(q_coords[2*CB +: CB]);
            cand_b    <= $signed(q_coords[3*CB +: CB]);
            pt_x      <= $signed(q_coords[4*CB +: CB]);
            pt_y      <= $signed(q_coords[5*CB +: CB]);
            scan_idx  <= '0;
            scan_last <= q_last;
            res_found <= 1'b0;
            res_hit   <= '0;
            res_side  <= SIDE_NONE;
            res_l     <= '0;
            res_t     <= '0;
            res_r     <= '0;
            res_b     <= '0;
            case (q_ctl.cmd)
              CMD_FIND:     state <= q_ctl.scan_none ? ST_DONE : ST_SCAN;
              CMD_CLASSIFY: state <= q_ctl.idx_ok ? ST_LOOK : ST_DONE;
              CMD_READ:     state <= q_ctl.idx_ok ? ST_LOOK : ST_DONE;
              default:      state <= ST_DONE;
            endcase
          end
        end
        ST_LOOK: begin
          if (cur_cmd == CMD_CLASSIFY) begin
            res_side <= side_calc;
          end else begin
            res_l <= g_l;
            res_t <= g_t;
            res_r <= g_r;
            res_b <= g_b;
          end
          state <= ST_DONE;
        end
        ST_SCAN: begin
          if (pt_in) begin
            res_found <= 1'b1;
            res_hit   <= INDEX_W'(scan_idx);
            state     <= ST_DONE;
          end else if (scan_idx == scan_last) begin
            state <= ST_DONE;
          end else begin
            scan_idx <= AW'(scan_idx + 1'b1);
          end
        end
        ST_DONE: begin
          if (o_load) begin
            o_kind  <= cur_cmd;
            o_found <= res_found;
            o_hit   <= res_hit;
            o_side  <= res_side;
            o_l     <= res_l;
            o_t     <= res_t;
            o_r     <= res_r;
            o_b     <= res_b;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_idx <= scan_last)
    else $error("scan index past last searched entry");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside done state");

  a_side_kind: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_kind != CMD_CLASSIFY |-> o_side == SIDE_NONE)
    else $error("side code set on non-classify item");

  a_found_kind: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_found |-> o_kind == CMD_FIND)
    else $error("hit flag set on non-find item");
`endif

endmodule

>>> rtl/core/rect_region_hit_table_unit.sv
`timescale 1ns / 1ps
// path: input register in rrht_front, two-item queue, then the rrht_back state
// machine; a find scans the table entries in order (one table read per cycle)
// the back end takes a new item only once its last result is in the output register;
// a two-item queue lets the input side keep accepting meanwhile
// reset: rst synchronous, clears region_count, queue and handshakes; table undefined

module rect_region_hit_table_unit import rrht_pkg::*; #(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                cfg_valid,
  output logic                                                cfg_ready,
  input  logic [COUNT_W-1:0]                                  cfg_data,
  input  logic                                                s_tvalid,
  output logic                                                s_tready,
  // entry_index, rect_left, rect_top, rect_right, rect_bottom, point_x, point_y
  input  logic [((INDEX_W + 6*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // cmd
  input  logic [KIND_W-1:0]                                   s_tuser,
  output logic                                                m_tvalid,
  input  logic                                                m_tready,
  // hit_found, hit_index, side_code, out_left, out_top, out_right, out_bottom
  output logic [((8 + 4*COORD_BITS + 7) / 8) * 8 - 1:0]       m_tdata,
  // result_kind
  output logic [KIND_W-1:0]                                   m_tuser
);

  localparam int AW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int QW  = CTL_W + 2*AW + 6*COORD_BITS;

  logic                   f_valid;
  logic                   f_ready;
  ctl_t                   f_ctl;
  logic [AW-1:0]          f_addr;
  logic [AW-1:0]          f_last;
  logic [6*COORD_BITS-1:0] f_coords;

  logic                   q_valid;
  logic                   q_ready;
  logic [QW-1:0]          q_data;
  ctl_t                   q_ctl;

  assign q_ctl = ctl_t'(q_data[CTL_W-1:0]);

  rrht_front #(
    .MAX_REGIONS (MAX_REGIONS),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_ctl     (f_ctl),
    .f_addr    (f_addr),
    .f_last    (f_last),
    .f_coords  (f_coords)
  );

  rrht_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_coords, f_last, f_addr, f_ctl}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  rrht_back #(
    .MAX_REGIONS (MAX_REGIONS),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_ctl    (q_ctl),
    .q_addr   (q_data[CTL_W +: AW]),
    .q_last   (q_data[CTL_W + AW +: AW]),
    .q_coords (q_data[CTL_W + 2*AW +: 6*COORD_BITS]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
